// ===== src/pgtl_pkg.sv =====
// Shared types and constants of the periodic grid target lookup.
`default_nettype none

package pgtl_pkg;

	// Cell index width for the largest grid (256 x 256 x 256 cells)
	localparam int IDX_W = 24;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 8;
	localparam int QPW         = 3;

	// Restoring divider: one quotient bit per step over a 65-bit numerator
	localparam int DIV_STEPS = 65;

	// Configuration port
	localparam int          CFG_AW      = 5;
	localparam logic [31:0] INV_LEN_RST = 32'h0100_0000;  // 1.0 in Q8.24

	localparam logic [2:0] REG_BOX_LO_X      = 3'd0;
	localparam logic [2:0] REG_BOX_LO_Y      = 3'd1;
	localparam logic [2:0] REG_BOX_LO_Z      = 3'd2;
	localparam logic [2:0] REG_BOX_INV_LEN_X = 3'd3;
	localparam logic [2:0] REG_BOX_INV_LEN_Y = 3'd4;
	localparam logic [2:0] REG_BOX_INV_LEN_Z = 3'd5;
	localparam logic [2:0] REG_RAMP_STEPS    = 3'd6;

	// Box geometry as seen by the front end
	typedef struct packed {
		logic signed [31:0] lo_x;
		logic signed [31:0] lo_y;
		logic signed [31:0] lo_z;
		logic [31:0]        inv_x;
		logic [31:0]        inv_y;
		logic [31:0]        inv_z;
	} pgtl_geom_t;

	// Classified command: query reads idx, write stores a/b at idx when wr_ok
	typedef struct packed {
		logic             query;
		logic             wr_ok;
		logic [IDX_W-1:0] idx;
		logic [31:0]      a;  // timestep for a query, density for a write
		logic [31:0]      b;  // cell size for a write
	} pgtl_cmd_t;

endpackage

`default_nettype wire

// ===== src/pgtl_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none

module pgtl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic                                       re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0]                           wdata,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// ===== src/pgtl_front.sv =====
// Front end: classifies items and maps positions to wrapped grid cells.
`default_nettype none

module pgtl_front import pgtl_pkg::*; #(
	parameter int GRID_X = 16,
	parameter int GRID_Y = 16,
	parameter int GRID_Z = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_vld,
	input  wire logic               op,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic [31:0]        timestep,
	input  wire logic [3:0]         cell_x,
	input  wire logic [3:0]         cell_y,
	input  wire logic [3:0]         cell_z,
	input  wire logic [31:0]        target_value,
	input  wire logic [31:0]        cell_size_value,
	input  wire pgtl_geom_t         geom,
	output logic                    cmd_vld,
	output pgtl_cmd_t               cmd
);

	localparam int CWX   = (GRID_X > 1) ? $clog2(GRID_X) : 1;
	localparam int CWY   = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
	localparam int CWZ   = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
	localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
	localparam int IW    = (CELLS > 1) ? $clog2(CELLS) : 1;

	localparam logic [8:0] GX = 9'(GRID_X);
	localparam logic [8:0] GY = 9'(GRID_Y);
	localparam logic [8:0] GZ = 9'(GRID_Z);

	typedef struct packed {
		logic        query;
		logic        wr_ok;
		logic [3:0]  cx;
		logic [3:0]  cy;
		logic [3:0]  cz;
		logic [31:0] a;
		logic [31:0] b;
	} pass_t;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	pass_t pass_in, pass_s1, pass_s2, pass_s3, pass_s4;

	logic [32:0] dx_s1, dy_s1, dz_s1;
	logic [31:0] mx_s2, my_s2, mz_s2;
	logic [2:0]  neg_s2, neg_s3, neg_s4;
	logic [39:0] fx_s3, fy_s3, fz_s3;
	logic [8:0]  rx_s4, ry_s4, rz_s4;
	pgtl_cmd_t   cmd_s5;

	logic [63:0] px, py, pz;
	logic [48:0] qx, qy, qz;
	logic [8:0]  sx, sy, sz;
	logic [CWX-1:0] ix;
	logic [CWY-1:0] iy;
	logic [CWZ-1:0] iz;
	logic [IW-1:0]  idx;

	// Write items are range checked here; queries carry the timestep in a
	always_comb begin
		pass_in.query = op;
		pass_in.wr_ok = ({5'b0, cell_x} < GX) && ({5'b0, cell_y} < GY) &&
		                ({5'b0, cell_z} < GZ);
		pass_in.cx    = cell_x;
		pass_in.cy    = cell_y;
		pass_in.cz    = cell_z;
		pass_in.a     = op ? timestep : target_value;
		pass_in.b     = cell_size_value;
	end

	// Only the 40 fraction bits of offset*inv matter: the whole part wraps away
	always_comb begin
		px = {32'b0, mx_s2} * {32'b0, geom.inv_x};
		py = {32'b0, my_s2} * {32'b0, geom.inv_y};
		pz = {32'b0, mz_s2} * {32'b0, geom.inv_z};
		qx = {9'b0, fx_s3} * {40'b0, GX};
		qy = {9'b0, fy_s3} * {40'b0, GY};
		qz = {9'b0, fz_s3} * {40'b0, GZ};
	end

	// Negative offsets wrap from the top of the axis
	always_comb begin
		sx = (neg_s4[0] && (rx_s4 != 9'd0)) ? (GX - rx_s4) : rx_s4;
		sy = (neg_s4[1] && (ry_s4 != 9'd0)) ? (GY - ry_s4) : ry_s4;
		sz = (neg_s4[2] && (rz_s4 != 9'd0)) ? (GZ - rz_s4) : rz_s4;
		if (!pass_s4.query) begin
			sx = {5'b0, pass_s4.cx};
			sy = {5'b0, pass_s4.cy};
			sz = {5'b0, pass_s4.cz};
		end
		ix  = sx[CWX-1:0];
		iy  = sy[CWY-1:0];
		iz  = sz[CWZ-1:0];
		idx = (IW'(ix) * IW'(GRID_Y) + IW'(iy)) * IW'(GRID_Z) + IW'(iz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		// s1: offsets from the box origin
		pass_s1 <= pass_in;
		dx_s1   <= {pos_x[31], pos_x} - {geom.lo_x[31], geom.lo_x};
		dy_s1   <= {pos_y[31], pos_y} - {geom.lo_y[31], geom.lo_y};
		dz_s1   <= {pos_z[31], pos_z} - {geom.lo_z[31], geom.lo_z};
		// s2: magnitude and sign
		pass_s2 <= pass_s1;
		neg_s2  <= {dz_s1[32], dy_s1[32], dx_s1[32]};
		mx_s2   <= dx_s1[32] ? 32'(-dx_s1) : dx_s1[31:0];
		my_s2   <= dy_s1[32] ? 32'(-dy_s1) : dy_s1[31:0];
		mz_s2   <= dz_s1[32] ? 32'(-dz_s1) : dz_s1[31:0];
		// s3: scale by the reciprocal length
		pass_s3 <= pass_s2;
		neg_s3  <= neg_s2;
		fx_s3   <= px[39:0];
		fy_s3   <= py[39:0];
		fz_s3   <= pz[39:0];
		// s4: scale by the grid size
		pass_s4 <= pass_s3;
		neg_s4  <= neg_s3;
		rx_s4   <= qx[48:40];
		ry_s4   <= qy[48:40];
		rz_s4   <= qz[48:40];
		// s5: flat table index
		cmd_s5.query <= pass_s4.query;
		cmd_s5.wr_ok <= pass_s4.wr_ok;
		cmd_s5.idx   <= IDX_W'(idx);
		cmd_s5.a     <= pass_s4.a;
		cmd_s5.b     <= pass_s4.b;
	end

	assign cmd_vld = vld_s5;
	assign cmd     = cmd_s5;

endmodule

`default_nettype wire

// ===== src/pgtl_cmd_fifo.sv =====
// Command queue between the front end and the back end.
`default_nettype none

module pgtl_cmd_fifo import pgtl_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire pgtl_cmd_t din,
	input  wire logic      pop,
	output pgtl_cmd_t      dout,
	output logic           empty,
	output logic           full
);

	pgtl_cmd_t      mem_q [QUEUE_DEPTH];
	logic [QPW:0]   wr_q, rd_q;

	assign empty = (wr_q == rd_q);
	assign full  = (wr_q[QPW] != rd_q[QPW]) && (wr_q[QPW-1:0] == rd_q[QPW-1:0]);
	assign dout  = mem_q[rd_q[QPW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + (QPW+1)'(1);
			end
			if (pop && !empty) begin
				rd_q <= rd_q + (QPW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q[QPW-1:0]] <= din;
		end
	end

endmodule

`default_nettype wire

// ===== src/pgtl_back.sv =====
// Back end: table access, density ramp divider and result register.
`default_nettype none

module pgtl_back import pgtl_pkg::*; #(
	parameter int CELLS = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_empty,
	input  wire pgtl_cmd_t   cmd,
	output logic             cmd_pop,
	input  wire logic [31:0] ramp_steps,
	input  wire logic        pop,
	output logic             empty,
	output logic [31:0]      density_target,
	output logic [31:0]      cell_size_target
);

	localparam int IW = (CELLS > 1) ? $clog2(CELLS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SUM,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   out_vld_q;
	logic   out_load;
	logic [31:0] dens_out_q, cs_out_q;

	logic [31:0] den_rd, cs_rd;
	logic        den_we, rd_en;
	logic [IW-1:0] addr;

	logic [31:0] t_q, den_q, cs_q, rem_q, quo_q;
	logic [63:0] prod_q;
	logic [64:0] num_q, sum;
	logic [6:0]  cnt_q;

	logic        ramp_on, ge, div_last;
	logic [32:0] shifted, diff;
	logic [31:0] rem_nxt;

	assign cmd_pop = (state_q == ST_IDLE) && !cmd_empty;
	assign addr    = cmd.idx[IW-1:0];
	assign den_we  = cmd_pop && !cmd.query && cmd.wr_ok;
	assign rd_en   = cmd_pop && cmd.query;

	// result register takes a new value when it is free or drained this cycle
	assign out_load = (state_q == ST_OUT) && (!out_vld_q || pop);

	pgtl_ram #(.WIDTH(32), .DEPTH(CELLS)) u_den_ram (
		.clk   (clk),
		.we    (den_we),
		.re    (rd_en),
		.addr  (addr),
		.wdata (cmd.a),
		.rdata (den_rd)
	);

	pgtl_ram #(.WIDTH(32), .DEPTH(CELLS)) u_cs_ram (
		.clk   (clk),
		.we    (den_we),
		.re    (rd_en),
		.addr  (addr),
		.wdata (cmd.b),
		.rdata (cs_rd)
	);

	always_comb begin
		ramp_on  = (ramp_steps != 32'd0) && (t_q <= ramp_steps);
		sum      = {17'b0, ramp_steps - t_q, 16'b0} + {1'b0, prod_q};
		shifted  = {rem_q, num_q[64]};
		diff     = shifted - {1'b0, ramp_steps};
		ge       = (shifted >= {1'b0, ramp_steps});
		rem_nxt  = ge ? diff[31:0] : shifted[31:0];
		div_last = (cnt_q == 7'(DIV_STEPS - 1));
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_pop) begin
					t_q <= cmd.a;
				end
			end
			ST_READ: begin
				den_q  <= den_rd;
				cs_q   <= cs_rd;
				prod_q <= {32'b0, den_rd} * {32'b0, t_q};
			end
			ST_SUM: begin
				num_q <= sum;
				rem_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				num_q <= {num_q[63:0], 1'b0};
				rem_q <= rem_nxt;
				quo_q <= {quo_q[30:0], ge};
				cnt_q <= cnt_q + 7'd1;
				if (div_last) begin
					den_q <= {quo_q[30:0], ge};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			out_vld_q  <= 1'b0;
			dens_out_q <= '0;
			cs_out_q   <= '0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (pop && out_vld_q) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop && cmd.query) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ramp_on ? ST_SUM : ST_OUT;
				ST_SUM:  state_q <= ST_DIV;
				ST_DIV: begin
					if (div_last) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						dens_out_q <= den_q;
						cs_out_q   <= cs_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign empty            = !out_vld_q;
	assign density_target   = dens_out_q;
	assign cell_size_target = cs_out_q;

endmodule

`default_nettype wire

// ===== src/periodic_grid_target_lookup.sv =====
// Top level of the periodic grid target lookup: config registers, front, queue, back.
// A query passes the front pipeline, the queue, the table read and the result register;
// with the ramp active it also passes the 65-step divider. Writes land when the back pops them.
// Throughput: the front takes one item per cycle while full is low; the back pops a
// new command only when idle, so ramped queries in the divider set the sustained rate.
// Reset clears control state and config registers; the tables stay undefined until written.
`default_nettype none

module periodic_grid_target_lookup import pgtl_pkg::*; #(
	parameter int GRID_X = 16,
	parameter int GRID_Y = 16,
	parameter int GRID_Z = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [CFG_AW-1:0]  paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	// item input
	input  wire logic               push,
	output logic                    full,
	input  wire logic               op,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic [31:0]        timestep,
	input  wire logic [3:0]         cell_x,
	input  wire logic [3:0]         cell_y,
	input  wire logic [3:0]         cell_z,
	input  wire logic [31:0]        target_value,
	input  wire logic [31:0]        cell_size_value,
	// results
	output logic                    empty,
	input  wire logic               pop,
	output logic [31:0]             density_target,
	output logic [31:0]             cell_size_target
);

	localparam int CELLS = GRID_X * GRID_Y * GRID_Z;

	// config registers
	pgtl_geom_t  geom_q;
	logic [31:0] ramp_steps_q;
	logic        cfg_wr;

	// front/back plumbing
	logic        accept;
	logic        cmd_vld, cmd_pop, fifo_empty, fifo_full;
	pgtl_cmd_t   cmd_in, cmd_out;
	logic [QPW:0] occ_q;

	// ------------------------------------------------------------------
	// Configuration port: no wait states, write on the access phase
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.lo_x  <= '0;
			geom_q.lo_y  <= '0;
			geom_q.lo_z  <= '0;
			geom_q.inv_x <= INV_LEN_RST;
			geom_q.inv_y <= INV_LEN_RST;
			geom_q.inv_z <= INV_LEN_RST;
			ramp_steps_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_BOX_LO_X:      geom_q.lo_x  <= pwdata;
				REG_BOX_LO_Y:      geom_q.lo_y  <= pwdata;
				REG_BOX_LO_Z:      geom_q.lo_z  <= pwdata;
				REG_BOX_INV_LEN_X: geom_q.inv_x <= pwdata;
				REG_BOX_INV_LEN_Y: geom_q.inv_y <= pwdata;
				REG_BOX_INV_LEN_Z: geom_q.inv_z <= pwdata;
				REG_RAMP_STEPS:    ramp_steps_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_BOX_LO_X:      prdata = geom_q.lo_x;
			REG_BOX_LO_Y:      prdata = geom_q.lo_y;
			REG_BOX_LO_Z:      prdata = geom_q.lo_z;
			REG_BOX_INV_LEN_X: prdata = geom_q.inv_x;
			REG_BOX_INV_LEN_Y: prdata = geom_q.inv_y;
			REG_BOX_INV_LEN_Z: prdata = geom_q.inv_z;
			REG_RAMP_STEPS:    prdata = ramp_steps_q;
			default:           prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Occupancy of front pipeline plus queue. The front never stalls, so
	// we stop taking transfers once every queue slot is spoken for.
	// ------------------------------------------------------------------
	assign full   = (occ_q == (QPW+1)'(QUEUE_DEPTH));
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + (QPW+1)'(accept) - (QPW+1)'(cmd_pop);
		end
	end

	// Front: offset, abs, scale by 1/L, scale by grid, wrap + flat index
	pgtl_front #(
		.GRID_X (GRID_X),
		.GRID_Y (GRID_Y),
		.GRID_Z (GRID_Z)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_vld          (accept),
		.op              (op),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.pos_z           (pos_z),
		.timestep        (timestep),
		.cell_x          (cell_x),
		.cell_y          (cell_y),
		.cell_z          (cell_z),
		.target_value    (target_value),
		.cell_size_value (cell_size_value),
		.geom            (geom_q),
		.cmd_vld         (cmd_vld),
		.cmd             (cmd_in)
	);

	// Queue keeps writes and queries in order, so a query sees every
	// earlier write to its cell
	pgtl_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_vld),
		.din    (cmd_in),
		.pop    (cmd_pop),
		.dout   (cmd_out),
		.empty  (fifo_empty),
		.full   (fifo_full)
	);

	// Back: tables, ramp blend (multiply, add, restoring divide), result register
	pgtl_back #(
		.CELLS (CELLS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_empty        (fifo_empty),
		.cmd              (cmd_out),
		.cmd_pop          (cmd_pop),
		.ramp_steps       (ramp_steps_q),
		.pop              (pop),
		.empty            (empty),
		.density_target   (density_target),
		.cell_size_target (cell_size_target)
	);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= (QPW+1)'(QUEUE_DEPTH))
		else $error("occupancy above queue depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_vld && fifo_full))
		else $error("front pushed into a full queue");

	a_occ_track: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cmd_pop) |=> (occ_q == $past(occ_q) + (QPW+1)'(1)))
		else $error("occupancy missed an input transfer");

endmodule

`default_nettype wire
